/* rtl/lns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_pkg
// Shared types, codes and helpers for the LCD nibble shift sequencer.
// ----------------------------------------------------------------------------
package lns_pkg;

	// request codes
	localparam logic [1:0] CMD_SEND   = 2'd0;
	localparam logic [1:0] CMD_CURSOR = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_INIT   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_RS_POS     = 3'd0;
	localparam logic [2:0] REG_EN_POS     = 3'd1;
	localparam logic [2:0] REG_DATA0_POS  = 3'd2;
	localparam logic [2:0] REG_DATA1_POS  = 3'd3;
	localparam logic [2:0] REG_DATA2_POS  = 3'd4;
	localparam logic [2:0] REG_DATA3_POS  = 3'd5;
	localparam logic [2:0] REG_LINE_LEN   = 3'd6;
	localparam logic [2:0] REG_LINE_COUNT = 3'd7;

	// display command bytes
	localparam logic [7:0] LCD_CLEAR     = 8'h01;
	localparam logic [7:0] LCD_ENTRY     = 8'h06;
	localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
	localparam logic [7:0] LCD_FUNC_2L   = 8'h28;
	localparam logic [7:0] LCD_FUNC_TALL = 8'h24;
	localparam logic [7:0] LCD_FUNC_1L   = 8'h20;
	localparam logic [7:0] LCD_DDRAM     = 8'h80;
	localparam logic [7:0] ROW1_OFFSET   = 8'h40;
	localparam logic [3:0] NIB_WAKE      = 4'h3;
	localparam logic [3:0] NIB_4BIT      = 4'h2;

	// one image update, each produces one output image
	typedef enum logic [2:0] {
		OP_RS,
		OP_HI,
		OP_LO,
		OP_EN0,
		OP_EN1,
		OP_NIB3,
		OP_NIB2
	} op_t;

	// which byte a byte sequence sends
	typedef enum logic [2:0] {
		BS_REQ,
		BS_FUNC,
		BS_DISP,
		BS_CLR,
		BS_ENTRY
	} bsel_t;

	typedef struct packed {
		logic  accept;
		logic  step;
		logic  last;
		op_t   op;
		bsel_t bsel;
	} ctrl_cmd_t;

	function automatic logic [7:0] put_bit(input logic [7:0] img, input logic [2:0] pos,
			input logic v);
		logic [7:0] r;
		r      = img;
		r[pos] = v;
		return r;
	endfunction

endpackage

/* rtl/lns_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_ctrl
// Sequencer: walks the nibble and byte steps of a request, one image a step.
// ----------------------------------------------------------------------------
module lns_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic               out_free,
	output lns_pkg::ctrl_cmd_t ctl
);
	import lns_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NIB,
		ST_BYTE
	} state_t;

	state_t     state_q;
	logic [3:0] sub_q;
	logic [1:0] idx_q;
	logic       init_q;
	logic       go;
	logic       seq_last;

	assign in_ready = (state_q == ST_IDLE);
	assign go       = (state_q != ST_IDLE) && out_free;
	assign seq_last = (state_q == ST_BYTE) && (sub_q == 4'd8) && (!init_q || idx_q == 2'd3);

	always_comb begin
		ctl.accept = in_valid && in_ready;
		ctl.step   = go;
		ctl.last   = seq_last;
		ctl.op     = OP_EN0;
		ctl.bsel   = BS_REQ;
		if (state_q == ST_NIB) begin
			unique case (sub_q[1:0])
				2'd0:    ctl.op = (idx_q == 2'd3) ? OP_NIB2 : OP_NIB3;
				2'd2:    ctl.op = OP_EN1;
				default: ctl.op = OP_EN0;
			endcase
		end else begin
			unique case (sub_q)
				4'd0:         ctl.op = OP_RS;
				4'd1:         ctl.op = OP_HI;
				4'd5:         ctl.op = OP_LO;
				4'd3, 4'd7:   ctl.op = OP_EN1;
				default:      ctl.op = OP_EN0;
			endcase
		end
		if (init_q) begin
			unique case (idx_q)
				2'd0:    ctl.bsel = BS_FUNC;
				2'd1:    ctl.bsel = BS_DISP;
				2'd2:    ctl.bsel = BS_CLR;
				default: ctl.bsel = BS_ENTRY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q   <= '0;
			idx_q   <= '0;
			init_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sub_q   <= '0;
						idx_q   <= '0;
						init_q  <= (cmd == CMD_INIT);
						state_q <= (cmd == CMD_INIT) ? ST_NIB : ST_BYTE;
					end
				end
				ST_NIB: begin
					if (go) begin
						if (sub_q == 4'd3) begin
							sub_q <= '0;
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd3)
								state_q <= ST_BYTE;
						end else begin
							sub_q <= sub_q + 4'd1;
						end
					end
				end
				default: begin
					if (go) begin
						if (sub_q == 4'd8) begin
							sub_q <= '0;
							idx_q <= idx_q + 2'd1;
							if (seq_last)
								state_q <= ST_IDLE;
						end else begin
							sub_q <= sub_q + 4'd1;
						end
					end
				end
			endcase
		end
	end

endmodule

/* rtl/lns_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_datapath
// Configuration registers, request bytes, the output image and its register.
// ----------------------------------------------------------------------------
module lns_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic [1:0]         cmd,
	input  logic [7:0]         byte_val,
	input  logic               rs_mode,
	input  logic [7:0]         column,
	input  logic [7:0]         line,
	input  logic               tall_font,
	input  lns_pkg::ctrl_cmd_t ctl,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         shift_word,
	output logic               last
);
	import lns_pkg::*;

	logic [2:0] rs_pos_q, en_pos_q, d0_pos_q, d1_pos_q, d2_pos_q, d3_pos_q;
	logic [7:0] line_len_q;
	logic [2:0] line_count_q;

	logic [7:0] image_q;
	logic [7:0] req_byte_q;
	logic [7:0] func_q;
	logic       mode_q;
	logic       out_valid_q;
	logic [7:0] word_q;
	logic       last_q;

	logic [2:0] lim;
	logic [7:0] row;
	logic [7:0] offset;
	logic [7:0] req_byte;
	logic [7:0] func_byte;
	logic [7:0] cur_byte;
	logic [3:0] nib;
	logic [7:0] next_image;

	// cursor address: clamp row, pick row offset
	always_comb begin
		if (line_count_q == 3'd0)
			lim = 3'd1;
		else if (line_count_q > 3'd4)
			lim = 3'd4;
		else
			lim = line_count_q;
		row = (line >= {5'd0, lim}) ? {5'd0, lim - 3'd1} : line;
		unique case (row[1:0])
			2'd0:    offset = 8'h00;
			2'd1:    offset = ROW1_OFFSET;
			2'd2:    offset = line_len_q;
			default: offset = ROW1_OFFSET + line_len_q;
		endcase
		unique case (cmd)
			CMD_SEND:   req_byte = byte_val;
			CMD_CURSOR: req_byte = LCD_DDRAM | (column + offset);
			default:    req_byte = LCD_CLEAR;
		endcase
		if (line_count_q > 3'd1)
			func_byte = LCD_FUNC_2L;
		else if (line_count_q == 3'd1 && tall_font)
			func_byte = LCD_FUNC_TALL;
		else
			func_byte = LCD_FUNC_1L;
	end

	always_comb begin
		unique case (ctl.bsel)
			BS_FUNC:  cur_byte = func_q;
			BS_DISP:  cur_byte = LCD_DISP_ON;
			BS_CLR:   cur_byte = LCD_CLEAR;
			BS_ENTRY: cur_byte = LCD_ENTRY;
			default:  cur_byte = req_byte_q;
		endcase
		unique case (ctl.op)
			OP_HI:   nib = cur_byte[7:4];
			OP_NIB3: nib = NIB_WAKE;
			OP_NIB2: nib = NIB_4BIT;
			default: nib = cur_byte[3:0];
		endcase
		// data lines in order d0..d3, later write wins on a shared position
		next_image = image_q;
		unique case (ctl.op)
			OP_RS:  next_image = put_bit(image_q, rs_pos_q, mode_q);
			OP_EN0: next_image = put_bit(image_q, en_pos_q, 1'b0);
			OP_EN1: next_image = put_bit(image_q, en_pos_q, 1'b1);
			default: begin
				next_image = put_bit(next_image, d0_pos_q, nib[0]);
				next_image = put_bit(next_image, d1_pos_q, nib[1]);
				next_image = put_bit(next_image, d2_pos_q, nib[2]);
				next_image = put_bit(next_image, d3_pos_q, nib[3]);
			end
		endcase
	end

	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign shift_word = word_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_pos_q     <= 3'd0;
			en_pos_q     <= 3'd1;
			d0_pos_q     <= 3'd2;
			d1_pos_q     <= 3'd3;
			d2_pos_q     <= 3'd4;
			d3_pos_q     <= 3'd5;
			line_len_q   <= 8'd16;
			line_count_q <= 3'd2;
			image_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RS_POS:    rs_pos_q     <= cfg_data[2:0];
					REG_EN_POS:    en_pos_q     <= cfg_data[2:0];
					REG_DATA0_POS: d0_pos_q     <= cfg_data[2:0];
					REG_DATA1_POS: d1_pos_q     <= cfg_data[2:0];
					REG_DATA2_POS: d2_pos_q     <= cfg_data[2:0];
					REG_DATA3_POS: d3_pos_q     <= cfg_data[2:0];
					REG_LINE_LEN:  line_len_q   <= cfg_data;
					default:       line_count_q <= cfg_data[2:0];
				endcase
			end
			if (ctl.accept && cmd == CMD_INIT)
				image_q <= '0;
			else if (ctl.step)
				image_q <= next_image;
			if (ctl.step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			req_byte_q <= req_byte;
			func_q     <= func_byte;
			mode_q     <= (cmd == CMD_SEND) ? rs_mode : 1'b0;
		end
		if (ctl.step) begin
			word_q <= next_image;
			last_q <= ctl.last;
		end
	end

endmodule

/* rtl/lcd_nibble_shift_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_shift_sequencer
// Character LCD 4-bit interface through an 8-bit shift register: emits the
// register images for byte send, cursor set, clear and init requests.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    cmd, byte_val, rs_mode, column, line, tall_font
//  out      out_valid / out_ready  shift_word, last
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One image per cycle from the sequencer while the output is not stalled: a send,
//  cursor or clear request issues 9 images after it is accepted, init issues 52.
//  A new request is taken only once the previous one has issued its last image.
//  A stalled output holds the sequencer; cfg is always ready.
//  Reset restores the default bit positions, 16 columns, 2 lines, image zero.
// ----------------------------------------------------------------------------
module lcd_nibble_shift_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] byte_val,
	input  logic       rs_mode,
	input  logic [7:0] column,
	input  logic [7:0] line,
	input  logic       tall_font,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] shift_word,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import lns_pkg::*;

	ctrl_cmd_t ctl;
	logic      out_free;

	assign cfg_ready = 1'b1;

	lns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.out_free (out_free),
		.ctl      (ctl)
	);

	lns_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.byte_val   (byte_val),
		.rs_mode    (rs_mode),
		.column     (column),
		.line       (line),
		.tall_font  (tall_font),
		.ctl        (ctl),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.shift_word (shift_word),
		.last       (last)
	);

endmodule
